// ===== src/assert_macros.svh =====
// assertion macros used by the positional array list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define PAL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define PAL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pal_pkg.sv =====
// shared types and constants for the positional array list
package pal_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int POS_W        = 4;
    localparam int DATA_W       = 32;
    localparam int LEN_W        = 4;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_DUMP,
        S_RESP
    } t_state;

endpackage

// ===== src/pal_if.sv =====
// request and response channel interfaces

// request channel: one list command
interface pal_cmd_if import pal_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_cmd                     command;
    logic        [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

// response channel: one result word
interface pal_rsp_if import pal_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [DATA_W-1:0] data;
    logic        [LEN_W-1:0]  length;
    logic                     last;

    modport source (output valid, status, data, length, last, input ready);
    modport sink   (input valid, status, data, length, last, output ready);
endinterface

// ===== src/positional_array_list.sv =====
// positional array list top level: sequencer over one entry ram
`include "assert_macros.svh"
// Bounded ordered list of signed 32-bit words, CAPACITY entries deep.
// i_cmd takes one request: insert value at position, delete at position,
// dump all entries, or clear. o_rsp returns results; last marks the final
// result of a request. Insert and delete give one result, dump gives one
// per entry (one result flagged empty if the list is empty), clear one.
// Entries live in a single-port-write ram with registered read; a small
// sequencer moves one entry per cycle through its shared index counter.
// Rejects and clear go straight to the result; insert and delete first
// shift the entries between the position and the list end, and dump
// streams its entries. i_cmd.ready returns once the sequencer is back
// in idle; a request may be accepted while the final result still
// sits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset (synchronous, active low) empties the list; entry contents are
// not cleared and are never read before being written.
module positional_array_list import pal_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pal_cmd_if.sink    i_cmd,
    pal_rsp_if.source  o_rsp
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // control state
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_src, n_src;
    logic r_pend, n_pend;
    logic r_out_valid, n_out_valid;

    // payload registers
    logic [CW-1:0]            r_pos, n_pos;
    logic signed [DATA_W-1:0] r_val, n_val;
    t_status                  r_res_status, n_res_status;
    logic signed [DATA_W-1:0] r_res_data, n_res_data;
    t_status                  r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic [LEN_W-1:0]         r_out_length, n_out_length;
    logic                     r_out_last, n_out_last;

    // ram port
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // helpers
    logic          accept;
    logic          out_free;
    logic          list_full;
    logic          list_empty;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic          idx_up;
    logic [CW-1:0] idx_step;
    logic          dump_take;

    pal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // handshake and list checks
    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign list_full   = (r_count == CW'(CAPACITY));
    assign list_empty  = (r_count == '0);
    assign pos_ext     = CMPW'(i_cmd.position);
    assign cnt_ext     = CMPW'(r_count);
    assign dump_take   = (r_state == S_DUMP) && r_pend && out_free;

    // shared index counter: down for insert shifts, up otherwise
    assign idx_up   = (r_state != S_INS);
    assign idx_step = idx_up ? (r_idx + 1'b1) : (r_idx - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.command)
                        CMD_INSERT: n_state = (list_full || pos_ext > cnt_ext) ? S_RESP : S_INS;
                        CMD_DELETE: n_state = (list_empty || pos_ext >= cnt_ext) ? S_RESP : S_DEL;
                        CMD_DUMP:   n_state = list_empty ? S_RESP : S_DUMP;
                        CMD_CLEAR:  n_state = S_RESP;
                    endcase
                end
            end
            S_INS: begin
                if (!r_pend && r_idx == r_pos) begin
                    n_state = S_RESP;
                end
            end
            S_DEL: begin
                if (!r_pend && r_idx == r_count) begin
                    n_state = S_RESP;
                end
            end
            S_DUMP: begin
                if (!r_pend && r_idx == r_count) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, ram control and output register loads
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_src        = r_src;
        n_pend       = r_pend;
        n_pos        = r_pos;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_length = r_out_length;
        n_out_last   = r_out_last;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_src[AW-1:0];
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos        = CW'(i_cmd.position);
                    n_val        = i_cmd.value;
                    n_pend       = 1'b0;
                    n_res_status = ST_OK;
                    n_res_data   = '0;
                    n_idx        = '0;
                    unique case (i_cmd.command)
                        CMD_INSERT: begin
                            n_idx = r_count;
                            if (list_full) begin
                                n_res_status = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                n_res_status = ST_BADPOS;
                            end
                        end
                        CMD_DELETE: begin
                            n_idx = CW'(i_cmd.position);
                            if (list_empty) begin
                                n_res_status = ST_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                n_res_status = ST_BADPOS;
                            end
                        end
                        CMD_DUMP: begin
                            if (list_empty) begin
                                n_res_status = ST_EMPTY;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            S_INS: begin
                // read entry below the hole, write it one place up next cycle
                ram_rd_addr = idx_step[AW-1:0];
                if (r_idx > r_pos) begin
                    ram_rd_en = 1'b1;
                    n_idx     = idx_step;
                    n_src     = r_idx;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_src[AW-1:0];
                    ram_wr_data = ram_rd_data;
                end else if (r_idx == r_pos) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_pos[AW-1:0];
                    ram_wr_data = r_val;
                    n_count     = r_count + 1'b1;
                end
            end
            S_DEL: begin
                // read upward from the position, first word is the removed one
                if (r_idx < r_count) begin
                    ram_rd_en = 1'b1;
                    n_idx     = idx_step;
                    n_src     = r_idx;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_src == r_pos) begin
                        n_res_data = ram_rd_data;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(r_src - 1'b1);
                        ram_wr_data = ram_rd_data;
                    end
                end else if (r_idx == r_count) begin
                    n_count = r_count - 1'b1;
                end
            end
            S_DUMP: begin
                // stream entries, read data holds while the output stalls
                if (dump_take) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_data   = ram_rd_data;
                    n_out_length = LEN_W'(r_count);
                    n_out_last   = (CW'(r_src + 1'b1) == r_count);
                    n_pend       = 1'b0;
                end
                if (r_idx < r_count && (!r_pend || out_free)) begin
                    ram_rd_en = 1'b1;
                    n_idx     = idx_step;
                    n_src     = r_idx;
                    n_pend    = 1'b1;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_out_length = LEN_W'(r_count);
                    n_out_last   = 1'b1;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_src       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_src       <= n_src;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_length <= n_out_length;
        r_out_last   <= n_out_last;
    end

    // response port
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.length = r_out_length;
    assign o_rsp.last   = r_out_last;

    // checks
    `PAL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `PAL_ASSERT_IMP(a_pend_in_work, i_clk, i_rst_n, r_pend, r_state == S_INS || r_state == S_DEL || r_state == S_DUMP, "read pending outside a shift or dump")
    `PAL_ASSERT_IMP(a_ins_idx, i_clk, i_rst_n, r_state == S_INS, r_idx >= r_pos && r_idx <= r_count, "insert index out of range")
    `PAL_ASSERT_IMP(a_dump_src, i_clk, i_rst_n, r_state == S_DUMP && r_pend, r_src < r_count, "dump read beyond count")
    `PAL_ASSERT_NXT(a_ins_grows, i_clk, i_rst_n, r_state == S_INS && n_state == S_RESP, r_count == $past(r_count) + 1'b1, "insert did not grow the list")

endmodule

// ===== src/pal_ram.sv =====
// generic single write port ram with registered read
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
